### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on every rising clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(name, cond, msg) \
	`ASSERT_CLK(name, !(cond), msg)

`endif

### rtl/core/sfa_pkg.sv
package sfa_pkg;

	// Field and register widths.
	localparam int TIME_W    = 40;
	localparam int DELTA_W   = 16;
	localparam int FT_W      = 24;
	localparam int FR_W      = 13;
	localparam int SIDE_W    = 9;
	localparam int FIRST_W   = 16;
	localparam int CELL_W    = 16;
	localparam int UV_W      = 17;
	localparam int SUM_W     = 17;
	localparam int DUR_W     = FT_W + FR_W;
	localparam int CELLS_W   = 2 * SIDE_W;
	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 24;
	localparam int OUT_DATA_W = 88;
	localparam int PC_W      = 5;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_GRID_COLUMNS    = 3'd0;
	localparam reg_idx_t REG_GRID_ROWS       = 3'd1;
	localparam reg_idx_t REG_CLIP_FIRST_CELL = 3'd2;
	localparam reg_idx_t REG_CLIP_FRAMES     = 3'd3;
	localparam reg_idx_t REG_LOOP_ENABLE     = 3'd4;
	localparam reg_idx_t REG_FRAME_TICKS     = 3'd5;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_TAKE,
		OP_DUR,
		OP_CLAMP,
		OP_STORE,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_DIV_DONE,
		OP_EMIT,
		OP_NOCLIP
	} uop_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_NO_CLIP,
		COND_NO_LOOP,
		COND_DIV_MORE,
		COND_OUT_BUSY
	} cond_t;

	typedef enum logic [2:0] {
		JOB_TMOD,
		JOB_LOCAL,
		JOB_CELLS,
		JOB_GRID,
		JOB_UL,
		JOB_VB,
		JOB_UR,
		JOB_VT
	} div_job_t;

	typedef logic [PC_W-1:0] pc_t;

	typedef struct packed {
		uop_t     op;
		cond_t    cond;
		div_job_t job;
		pc_t      target;
	} ctrl_t;

	typedef struct packed {
		logic start;
		logic step;
	} div_ctl_t;

	localparam pc_t PC_WAIT   = 5'd0;
	localparam pc_t PC_TMOD_STEP = 5'd4;
	localparam pc_t PC_CLAMP  = 5'd6;
	localparam pc_t PC_STORE  = 5'd7;
	localparam pc_t PC_LOCAL_STEP = 5'd9;
	localparam pc_t PC_CELLS_STEP = 5'd12;
	localparam pc_t PC_GRID_STEP  = 5'd15;
	localparam pc_t PC_UL_STEP    = 5'd18;
	localparam pc_t PC_VB_STEP    = 5'd21;
	localparam pc_t PC_UR_STEP    = 5'd24;
	localparam pc_t PC_VT_STEP    = 5'd27;
	localparam pc_t PC_EMIT   = 5'd29;
	localparam pc_t PC_NOCLIP = 5'd31;

	function automatic ctrl_t uword(uop_t op, cond_t cond, div_job_t job, pc_t target);
		ctrl_t w;
		w.op     = op;
		w.cond   = cond;
		w.job    = job;
		w.target = target;
		return w;
	endfunction

	// Control store. A step branches to its target when its condition holds,
	// otherwise it falls through to the next step.
	function automatic ctrl_t ucode(pc_t pc);
		ctrl_t w;
		case (pc)
			5'd0:  w = uword(OP_TAKE,      COND_NO_INPUT, JOB_TMOD,  PC_WAIT);
			5'd1:  w = uword(OP_DUR,       COND_NO_CLIP,  JOB_TMOD,  PC_NOCLIP);
			5'd2:  w = uword(OP_NOP,       COND_NO_LOOP,  JOB_TMOD,  PC_CLAMP);
			5'd3:  w = uword(OP_DIV_START, COND_NEVER,    JOB_TMOD,  PC_WAIT);
			5'd4:  w = uword(OP_DIV_STEP,  COND_DIV_MORE, JOB_TMOD,  PC_TMOD_STEP);
			5'd5:  w = uword(OP_DIV_DONE,  COND_ALWAYS,   JOB_TMOD,  PC_STORE);
			5'd6:  w = uword(OP_CLAMP,     COND_NEVER,    JOB_TMOD,  PC_WAIT);
			5'd7:  w = uword(OP_STORE,     COND_NEVER,    JOB_TMOD,  PC_WAIT);
			5'd8:  w = uword(OP_DIV_START, COND_NEVER,    JOB_LOCAL, PC_WAIT);
			5'd9:  w = uword(OP_DIV_STEP,  COND_DIV_MORE, JOB_LOCAL, PC_LOCAL_STEP);
			5'd10: w = uword(OP_DIV_DONE,  COND_NEVER,    JOB_LOCAL, PC_WAIT);
			5'd11: w = uword(OP_DIV_START, COND_NEVER,    JOB_CELLS, PC_WAIT);
			5'd12: w = uword(OP_DIV_STEP,  COND_DIV_MORE, JOB_CELLS, PC_CELLS_STEP);
			5'd13: w = uword(OP_DIV_DONE,  COND_NEVER,    JOB_CELLS, PC_WAIT);
			5'd14: w = uword(OP_DIV_START, COND_NEVER,    JOB_GRID,  PC_WAIT);
			5'd15: w = uword(OP_DIV_STEP,  COND_DIV_MORE, JOB_GRID,  PC_GRID_STEP);
			5'd16: w = uword(OP_DIV_DONE,  COND_NEVER,    JOB_GRID,  PC_WAIT);
			5'd17: w = uword(OP_DIV_START, COND_NEVER,    JOB_UL,    PC_WAIT);
			5'd18: w = uword(OP_DIV_STEP,  COND_DIV_MORE, JOB_UL,    PC_UL_STEP);
			5'd19: w = uword(OP_DIV_DONE,  COND_NEVER,    JOB_UL,    PC_WAIT);
			5'd20: w = uword(OP_DIV_START, COND_NEVER,    JOB_VB,    PC_WAIT);
			5'd21: w = uword(OP_DIV_STEP,  COND_DIV_MORE, JOB_VB,    PC_VB_STEP);
			5'd22: w = uword(OP_DIV_DONE,  COND_NEVER,    JOB_VB,    PC_WAIT);
			5'd23: w = uword(OP_DIV_START, COND_NEVER,    JOB_UR,    PC_WAIT);
			5'd24: w = uword(OP_DIV_STEP,  COND_DIV_MORE, JOB_UR,    PC_UR_STEP);
			5'd25: w = uword(OP_DIV_DONE,  COND_NEVER,    JOB_UR,    PC_WAIT);
			5'd26: w = uword(OP_DIV_START, COND_NEVER,    JOB_VT,    PC_WAIT);
			5'd27: w = uword(OP_DIV_STEP,  COND_DIV_MORE, JOB_VT,    PC_VT_STEP);
			5'd28: w = uword(OP_DIV_DONE,  COND_NEVER,    JOB_VT,    PC_WAIT);
			5'd29: w = uword(OP_EMIT,      COND_OUT_BUSY, JOB_TMOD,  PC_EMIT);
			5'd30: w = uword(OP_NOP,       COND_ALWAYS,   JOB_TMOD,  PC_WAIT);
			5'd31: w = uword(OP_NOCLIP,    COND_ALWAYS,   JOB_TMOD,  PC_EMIT);
			default: w = uword(OP_NOP,     COND_ALWAYS,   JOB_TMOD,  PC_WAIT);
		endcase
		return w;
	endfunction

endpackage

### rtl/core/sprite_frame_animator_core.sv
// Channel  Direction  Payload
// cfg      in         cfg_idx register index, cfg_wdata value, written when cfg_we is high
// s_*      in         tdata: delta_time[15:0]; tuser: restart
// m_*      out        tdata: cell_index, u_left, v_bottom, u_right, v_top; tuser: updated;
//                     tlast: finished
//
// A single bit-serial divider is shared by all divisions of a tick: eight in
// loop mode, seven otherwise, and none when no clip is loaded.
// A finished result waits in the output register while the next tick is taken;
// the sequencer stalls only when it must overwrite a result not yet taken.
// Reset clears the configuration to its defaults and the clip time to zero.
`include "assert_macros.svh"

module sprite_frame_animator_core #(
	parameter int UV_FRACTION_BITS    = 16,
	parameter int MAX_GRID_SIDE       = 256,
	parameter int DEFAULT_FRAME_TICKS = 8192
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sfa_pkg::REG_IDX_W-1:0]   cfg_idx,
	input  logic [sfa_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [sfa_pkg::DELTA_W-1:0]     s_tdata,   // delta_time[15:0]
	input  logic                            s_tuser,   // restart
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// cell_index[15:0], u_left[32:16], v_bottom[49:33], u_right[66:50],
	// v_top[83:67], zero fill[87:84]
	output logic [sfa_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tuser,   // updated
	output logic                            m_tlast    // finished
);
	import sfa_pkg::*;

	localparam int T_W    = TIME_W + 1;
	localparam int UV_SH  = UV_FRACTION_BITS + 1;
	localparam int UV_DW  = UV_SH + SIDE_W + 1;
	localparam int DIV_DW = (T_W > UV_DW) ? T_W : UV_DW;
	localparam int DIV_VW = DUR_W;
	localparam int CNT_W  = $clog2(DIV_DW + 1);

	function automatic logic [SIDE_W-1:0] side_value(logic [SIDE_W-1:0] v);
		if (v == '0) begin
			return SIDE_W'(1);
		end else if (int'(v) > MAX_GRID_SIDE) begin
			return SIDE_W'(MAX_GRID_SIDE);
		end
		return v;
	endfunction

	// Configuration registers.
	logic [SIDE_W-1:0]  cols_q;
	logic [SIDE_W-1:0]  rows_q;
	logic [FIRST_W-1:0] first_q;
	logic [FR_W-1:0]    frames_q;
	logic               loop_q;
	logic [FT_W-1:0]    fticks_q;

	// Sequencer.
	pc_t   pc_q;
	pc_t   pc_d;
	ctrl_t ctrl;
	logic  branch;

	// Datapath.
	logic [TIME_W-1:0]  clip_time_q;
	logic [T_W-1:0]     t_q;
	logic [DUR_W-1:0]   dur_q;
	logic [DUR_W-1:0]   dur_m1;
	logic [CELLS_W-1:0] cells_q;
	logic [SUM_W-1:0]   lin_q;
	logic [SIDE_W-1:0]  col_q;
	logic [SIDE_W-1:0]  row_q;
	logic [UV_W-1:0]    ul_q;
	logic [UV_W-1:0]    vb_q;
	logic [UV_W-1:0]    ur_q;
	logic [UV_W-1:0]    vt_q;
	logic               fin_q;
	logic               upd_q;
	logic [FT_W-1:0]    ft;
	logic [DUR_W-1:0]   dur_prod;
	logic [CELLS_W-1:0] cells_prod;
	logic               s_fire;

	// Divider operands and results.
	div_ctl_t           div_ctl;
	logic [SIDE_W-1:0]  uv_num;
	logic [SIDE_W-1:0]  uv_den;
	logic [DIV_DW-1:0]  uv_d;
	logic [DIV_DW-1:0]  op_d;
	logic [DIV_VW-1:0]  op_v;
	logic [DIV_VW-1:0]  rem_init;
	logic [DIV_DW-1:0]  quo_init;
	logic [CNT_W-1:0]   op_k;
	logic [DIV_DW-1:0]  div_quo;
	logic [DIV_VW-1:0]  div_rem;
	logic               div_more;

	// Output register.
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                  m_tuser_q;
	logic                  m_tlast_q;
	logic                  out_busy;
	logic                  emit_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= SIDE_W'(1);
			rows_q   <= SIDE_W'(1);
			first_q  <= '0;
			frames_q <= '0;
			loop_q   <= 1'b0;
			fticks_q <= 24'd8192;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GRID_COLUMNS:    cols_q   <= side_value(cfg_wdata[SIDE_W-1:0]);
				REG_GRID_ROWS:       rows_q   <= side_value(cfg_wdata[SIDE_W-1:0]);
				REG_CLIP_FIRST_CELL: first_q  <= cfg_wdata[FIRST_W-1:0];
				REG_CLIP_FRAMES:     frames_q <= cfg_wdata[FR_W-1:0];
				REG_LOOP_ENABLE:     loop_q   <= cfg_wdata[0];
				REG_FRAME_TICKS:     fticks_q <= cfg_wdata[FT_W-1:0];
				default: ;
			endcase
		end
	end

	// Control store and branch logic.
	always_comb begin
		ctrl = ucode(pc_q);
		case (ctrl.cond)
			COND_NEVER:    branch = 1'b0;
			COND_ALWAYS:   branch = 1'b1;
			COND_NO_INPUT: branch = !s_tvalid;
			COND_NO_CLIP:  branch = frames_q == '0;
			COND_NO_LOOP:  branch = !loop_q;
			COND_DIV_MORE: branch = div_more;
			COND_OUT_BUSY: branch = out_busy;
			default:       branch = 1'b0;
		endcase
		pc_d = branch ? ctrl.target : pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

	assign s_tready  = ctrl.op == OP_TAKE;
	assign s_fire    = s_tvalid && s_tready;
	assign out_busy  = m_tvalid_q && !m_tready;
	assign emit_fire = (ctrl.op == OP_EMIT) && !out_busy;

	always_comb begin
		ft         = (fticks_q == '0) ? FT_W'(DEFAULT_FRAME_TICKS) : fticks_q;
		dur_prod   = DUR_W'(ft) * DUR_W'(frames_q);
		cells_prod = CELLS_W'(cols_q) * CELLS_W'(rows_q);
		dur_m1     = dur_q - 1'b1;
	end

	// Operand selection. Each job shifts its dividend so that the quotient
	// fits in the given number of steps and the first partial remainder is
	// already below the divisor.
	always_comb begin
		case (ctrl.job)
			JOB_UL:  begin uv_num = col_q;        uv_den = cols_q; end
			JOB_VB:  begin uv_num = row_q;        uv_den = rows_q; end
			JOB_UR:  begin uv_num = col_q + 1'b1; uv_den = cols_q; end
			JOB_VT:  begin uv_num = row_q + 1'b1; uv_den = rows_q; end
			default: begin uv_num = col_q;        uv_den = cols_q; end
		endcase
		// Rounded to nearest: (2 * num * 2^F + den) / (2 * den).
		uv_d = (DIV_DW'(uv_num) << UV_SH) + DIV_DW'(uv_den);

		case (ctrl.job)
			JOB_TMOD: begin
				op_d     = DIV_DW'(t_q);
				op_v     = dur_q;
				op_k     = CNT_W'(T_W);
				rem_init = DIV_VW'(op_d >> T_W);
				quo_init = op_d << (DIV_DW - T_W);
			end
			JOB_LOCAL: begin
				op_d     = DIV_DW'(t_q);
				op_v     = DIV_VW'(ft);
				op_k     = CNT_W'(FR_W);
				rem_init = DIV_VW'(op_d >> FR_W);
				quo_init = op_d << (DIV_DW - FR_W);
			end
			JOB_CELLS: begin
				op_d     = DIV_DW'(lin_q);
				op_v     = DIV_VW'(cells_q);
				op_k     = CNT_W'(SUM_W);
				rem_init = DIV_VW'(op_d >> SUM_W);
				quo_init = op_d << (DIV_DW - SUM_W);
			end
			JOB_GRID: begin
				op_d     = DIV_DW'(lin_q);
				op_v     = DIV_VW'(cols_q);
				op_k     = CNT_W'(SIDE_W);
				rem_init = DIV_VW'(op_d >> SIDE_W);
				quo_init = op_d << (DIV_DW - SIDE_W);
			end
			JOB_UL, JOB_VB, JOB_UR, JOB_VT: begin
				op_d     = uv_d;
				op_v     = DIV_VW'({uv_den, 1'b0});
				op_k     = CNT_W'(UV_SH);
				rem_init = DIV_VW'(op_d >> UV_SH);
				quo_init = op_d << (DIV_DW - UV_SH);
			end
			default: begin
				op_d     = '0;
				op_v     = '0;
				op_k     = '0;
				rem_init = '0;
				quo_init = '0;
			end
		endcase

		div_ctl.start = ctrl.op == OP_DIV_START;
		div_ctl.step  = ctrl.op == OP_DIV_STEP;
	end

	sfa_div #(
		.DW    (DIV_DW),
		.VW    (DIV_VW),
		.CNT_W (CNT_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.rem_init  (rem_init),
		.quo_init  (quo_init),
		.divisor   (op_v),
		.iters     (op_k),
		.quotient  (div_quo),
		.remainder (div_rem),
		.more      (div_more)
	);

	// Clip time is architectural state and survives between ticks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_time_q <= '0;
		end else if (s_fire && s_tuser) begin
			clip_time_q <= '0;
		end else if (ctrl.op == OP_STORE) begin
			clip_time_q <= t_q[TIME_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_TAKE: begin
				if (s_fire) begin
					t_q <= (s_tuser ? T_W'(0) : T_W'(clip_time_q)) + T_W'(s_tdata);
				end
			end
			OP_DUR: begin
				dur_q   <= dur_prod;
				cells_q <= cells_prod;
				upd_q   <= frames_q != '0;
			end
			OP_CLAMP: begin
				if (t_q > T_W'(dur_m1)) begin
					t_q <= T_W'(dur_m1);
				end
			end
			OP_STORE: begin
				fin_q <= !loop_q && (t_q >= T_W'(dur_m1));
			end
			OP_DIV_DONE: begin
				case (ctrl.job)
					JOB_TMOD:  t_q   <= T_W'(div_rem);
					JOB_LOCAL: lin_q <= SUM_W'(first_q) + SUM_W'(div_quo[FR_W-1:0]);
					JOB_CELLS: lin_q <= div_rem[SUM_W-1:0];
					JOB_GRID: begin
						col_q <= div_rem[SIDE_W-1:0];
						row_q <= div_quo[SIDE_W-1:0];
					end
					JOB_UL:  ul_q <= div_quo[UV_W-1:0];
					JOB_VB:  vb_q <= div_quo[UV_W-1:0];
					JOB_UR:  ur_q <= div_quo[UV_W-1:0];
					JOB_VT:  vt_q <= div_quo[UV_W-1:0];
					default: ;
				endcase
			end
			OP_NOCLIP: begin
				lin_q <= '0;
				ul_q  <= '0;
				vb_q  <= '0;
				ur_q  <= '0;
				vt_q  <= '0;
				fin_q <= 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_tdata_q <= {4'b0, vt_q, ur_q, vb_q, ul_q, lin_q[CELL_W-1:0]};
			m_tuser_q <= upd_q;
			m_tlast_q <= fin_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	`ASSERT_CLK(a_take_closes_input, s_fire |=> !s_tready, "input still open after a tick")
	`ASSERT_CLK(a_time_in_clip, (ctrl.op == OP_STORE) |-> (t_q < T_W'(dur_q)), "clip time not reduced")
	`ASSERT_CLK(a_local_in_clip, (ctrl.op == OP_DIV_DONE && ctrl.job == JOB_LOCAL) |-> (div_quo < DIV_DW'(frames_q)), "local frame out of clip")
	`ASSERT_NEVER(a_cell_in_grid, ctrl.op == OP_EMIT && upd_q && (col_q >= cols_q || row_q >= rows_q), "cell outside grid")

endmodule

### rtl/core/sfa_div.sv
// Restoring divider, one quotient bit per cycle. The caller pre-aligns the
// dividend so that the requested number of steps produces the full quotient.
module sfa_div #(
	parameter int DW    = 41,
	parameter int VW    = 37,
	parameter int CNT_W = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sfa_pkg::div_ctl_t    ctl,
	input  logic [VW-1:0]        rem_init,
	input  logic [DW-1:0]        quo_init,
	input  logic [VW-1:0]        divisor,
	input  logic [CNT_W-1:0]     iters,
	output logic [DW-1:0]        quotient,
	output logic [VW-1:0]        remainder,
	output logic                 more
);
	import sfa_pkg::*;

	logic [VW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VW:0]      trial;
	logic [VW:0]      diff;
	logic             ge;
	logic             active;

	always_comb begin
		trial  = {rem_q, quo_q[DW-1]};
		diff   = trial - {1'b0, dvs_q};
		ge     = trial >= {1'b0, dvs_q};
		active = ctl.step && (cnt_q != '0);
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= rem_init;
			quo_q <= quo_init;
			dvs_q <= divisor;
		end else if (active) begin
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= iters;
		end else if (active) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign more      = cnt_q > CNT_W'(1);

endmodule

### dv/sprite_frame_animator_core_tb.sv
`timescale 1ns / 1ps

module sprite_frame_animator_core_tb;
	import sfa_pkg::*;

	localparam int UV_BITS        = 16;
	localparam int GRID_MAX       = 256;
	localparam int DEFAULT_TICKS  = 8192;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 2000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int TICK_TARGET    = 1725;

	// Indexes with no register behind them; writes there must change nothing.
	localparam reg_idx_t REG_SPARE_6 = 3'd6;
	localparam reg_idx_t REG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic        updated;
		logic [15:0] cell_index;
		logic [16:0] u_left;
		logic [16:0] v_bottom;
		logic [16:0] u_right;
		logic [16:0] v_top;
		logic        finished;
	} sprite_view_t;

	class sprite_view_tracker;
		logic [8:0]  cols;
		logic [8:0]  rows;
		logic [15:0] first_cell;
		logic [12:0] frames;
		logic        loop_on;
		logic [23:0] fticks;
		logic [39:0] clip_time;
		sprite_view_t due_views[$];
		int errors;
		int views_seen;

		function new();
			cols       = 9'd1;
			rows       = 9'd1;
			first_cell = '0;
			frames     = '0;
			loop_on    = 1'b0;
			fticks     = 24'd8192;
			clip_time  = '0;
			errors     = 0;
			views_seen = 0;
		endfunction

		function logic [8:0] side_of(logic [8:0] v);
			if (v == 0)
				return 9'd1;
			if (v > GRID_MAX)
				return 9'(GRID_MAX);
			return v;
		endfunction

		// Rounded num / den in Q1.16, ties going up, kept to the 17-bit field.
		function logic [16:0] frac_of(longint unsigned num, longint unsigned den);
			return 17'((((num << UV_BITS) * 2) + den) / (den * 2));
		endfunction

		function void write_reg(reg_idx_t idx, logic [23:0] val);
			case (idx)
				REG_GRID_COLUMNS:    cols       = side_of(val[8:0]);
				REG_GRID_ROWS:       rows       = side_of(val[8:0]);
				REG_CLIP_FIRST_CELL: first_cell = val[15:0];
				REG_CLIP_FRAMES:     frames     = val[12:0];
				REG_LOOP_ENABLE:     loop_on    = val[0];
				REG_FRAME_TICKS:     fticks     = val;
				default: ;
			endcase
		endfunction

		function void note_tick(logic [15:0] delta, logic restart);
			longint unsigned ft, dur, t, frame_no, cells, linear, col, row;
			sprite_view_t v;
			v = '0;
			if (restart)
				clip_time = '0;
			if (frames == 0) begin
				v.finished = 1'b1;
			end else begin
				ft  = (fticks == 0) ? DEFAULT_TICKS : longint'(fticks);
				dur = ft * longint'(frames);
				t   = longint'(clip_time) + longint'(delta);
				if (loop_on)
					t = t % dur;
				else if (t > dur - 1)
					t = dur - 1;
				clip_time = t[39:0];
				frame_no = t / ft;
				if (loop_on)
					frame_no = frame_no % frames;
				else if (frame_no > frames - 1)
					frame_no = frames - 1;
				cells  = longint'(cols) * longint'(rows);
				linear = (longint'(first_cell) + frame_no) % cells;
				col    = linear % cols;
				row    = linear / cols;
				v.updated    = 1'b1;
				v.cell_index = linear[15:0];
				v.u_left     = frac_of(col, cols);
				v.v_bottom   = frac_of(row, rows);
				v.u_right    = frac_of(col + 1, cols);
				v.v_top      = frac_of(row + 1, rows);
				v.finished   = !loop_on && (t >= dur - 1);
			end
			due_views.push_back(v);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("view %0d %s got 0x%0h want 0x%0h",
					views_seen, name, got, want));
		endtask

		task check_view(logic [OUT_DATA_W-1:0] data, logic upd, logic fin);
			sprite_view_t want;
			if (due_views.size() == 0) begin
				report("view arrived with no tick outstanding");
				return;
			end
			want = due_views.pop_front();
			views_seen++;
			compare_field("updated", upd, want.updated);
			compare_field("cell_index", data[15:0], want.cell_index);
			compare_field("u_left", data[32:16], want.u_left);
			compare_field("v_bottom", data[49:33], want.v_bottom);
			compare_field("u_right", data[66:50], want.u_right);
			compare_field("v_top", data[83:67], want.v_top);
			compare_field("fill", data[87:84], 4'd0);
			compare_field("finished", fin, want.finished);
		endtask

		task check_leftover();
			if (due_views.size() != 0)
				report($sformatf("%0d views never arrived", due_views.size()));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	reg_idx_t              cfg_idx;
	logic [CFG_W-1:0]      cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [DELTA_W-1:0]    s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	sprite_view_tracker views;
	logic idle_on;
	logic hold_pending;
	int   ticks_sent;
	int   quiet_cycles;
	int   phase;
	int   burst;

	sprite_frame_animator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_pending = 1'b0;
			end
			m_tready <= !idle_on || ($urandom_range(99) >= 31);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			views.check_view(m_tdata, m_tuser, m_tlast);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_reg(reg_idx_t idx, logic [23:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		views.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic send_tick(logic [15:0] delta, logic restart);
		s_tvalid <= 1'b1;
		s_tdata  <= delta;
		s_tuser  <= restart;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		views.note_tick(delta, restart);
		ticks_sent++;
		if (idle_on && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			repeat (($urandom_range(3) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (views.due_views.size() != 0)
			@(posedge clk);
	endtask

	// Random bits above the register width; the block must drop them.
	function automatic logic [23:0] with_junk(logic [23:0] val, int width);
		if (width < 24 && $urandom_range(3) == 0)
			return val | 24'($urandom << width);
		return val;
	endfunction

	function automatic logic [15:0] pick_delta();
		int unsigned span;
		span = (views.fticks == 0) ? DEFAULT_TICKS : views.fticks;
		if (span > 65535)
			span = 65535;
		case ($urandom_range(9))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2, 3:    return 16'($urandom_range(65535));
			4, 5, 6: return 16'($urandom_range(span));
			default: return 16'($urandom_range(span / 8 + 1));
		endcase
	endfunction

	function automatic logic [23:0] pick_side();
		case ($urandom_range(9))
			0:       return 24'd0;
			1:       return 24'($urandom_range(257, 511));
			2:       return 24'd256;
			3:       return 24'($urandom_range(1, 256));
			default: return 24'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic logic [23:0] pick_frames();
		case ($urandom_range(19))
			0, 1:          return 24'd0;
			2:             return 24'd1;
			3, 4, 5, 6,
			7, 8, 9:       return 24'($urandom_range(1, 8));
			10, 11, 12,
			13, 14:        return 24'($urandom_range(9, 64));
			15, 16, 17:    return 24'($urandom_range(65, 600));
			default:       return 24'($urandom_range(4096, 8191));
		endcase
	endfunction

	function automatic logic [23:0] pick_ticks();
		case ($urandom_range(19))
			0, 1, 2:       return 24'd0;
			3, 4, 5:       return 24'($urandom_range(1, 64));
			6, 7, 8, 9,
			10, 11, 12:    return 24'($urandom_range(65, 3000));
			13, 14, 15,
			16:            return 24'($urandom_range(3001, 65535));
			default:       return 24'($urandom_range(65536, 24'hFFFFFF));
		endcase
	endfunction

	task automatic shuffle_settings();
		set_reg(REG_GRID_COLUMNS, with_junk(pick_side(), 9));
		set_reg(REG_GRID_ROWS, with_junk(pick_side(), 9));
		set_reg(REG_CLIP_FIRST_CELL, with_junk(($urandom_range(1) != 0) ?
			24'($urandom_range(65535)) : 24'($urandom_range(40)), 16));
		set_reg(REG_CLIP_FRAMES, with_junk(pick_frames(), 13));
		set_reg(REG_LOOP_ENABLE, with_junk(24'($urandom_range(1)), 1));
		set_reg(REG_FRAME_TICKS, pick_ticks());
		if ($urandom_range(4) == 0)
			set_reg(($urandom_range(1) != 0) ? REG_SPARE_6 : REG_SPARE_7, 24'($urandom));
	endtask

	initial begin
		views        = new();
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = REG_GRID_COLUMNS;
		cfg_wdata    = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = 1'b0;
		idle_on      = 1'b1;
		hold_pending = 1'b0;
		ticks_sent   = 0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset no clip is loaded: every tick reports finished, nothing updated.
		send_tick(16'hFFFF, 1'b1);
		send_tick(16'd0, 1'b0);
		send_tick(16'h1234, 1'b0);
		wait_drained();

		// Small looping clip that wraps several times.
		set_reg(REG_GRID_COLUMNS, 24'd4);
		set_reg(REG_GRID_ROWS, 24'd3);
		set_reg(REG_CLIP_FIRST_CELL, 24'd5);
		set_reg(REG_CLIP_FRAMES, 24'd6);
		set_reg(REG_LOOP_ENABLE, 24'd1);
		set_reg(REG_FRAME_TICKS, 24'd1000);
		send_tick(16'd0, 1'b1);
		send_tick(16'd999, 1'b0);
		send_tick(16'd1, 1'b0);
		send_tick(16'd4000, 1'b0);
		send_tick(16'hFFFF, 1'b0);
		send_tick(16'd1500, 1'b1);
		wait_drained();

		// Held last frame at the default frame length, a saturated column count, a zero row count,
		// first cell wrapping around the grid, and junk above the row, first-cell and loop registers.
		set_reg(REG_GRID_COLUMNS, 24'h0001FF);
		set_reg(REG_GRID_ROWS, 24'hFFFE00);
		set_reg(REG_CLIP_FIRST_CELL, 24'hFFFFFF);
		set_reg(REG_CLIP_FRAMES, 24'd3);
		set_reg(REG_LOOP_ENABLE, 24'hFFFFFE);
		set_reg(REG_FRAME_TICKS, 24'd0);
		send_tick(16'hFFFF, 1'b1);
		send_tick(16'hFFFF, 1'b0);
		send_tick(16'd0, 1'b0);
		send_tick(16'd0, 1'b1);
		wait_drained();

		// Largest clip on the largest grid; the spare indexes must do nothing.
		set_reg(REG_GRID_COLUMNS, 24'd256);
		set_reg(REG_GRID_ROWS, 24'd256);
		set_reg(REG_CLIP_FRAMES, 24'hFFFFFF);
		set_reg(REG_LOOP_ENABLE, 24'd1);
		set_reg(REG_FRAME_TICKS, 24'hFFFFFF);
		set_reg(REG_SPARE_6, 24'hFFFFFF);
		set_reg(REG_SPARE_7, 24'd0);
		send_tick(16'hFFFF, 1'b1);
		send_tick(16'hFFFF, 1'b0);
		send_tick(16'd0, 1'b0);
		wait_drained();

		// A one-unit clip sits at its end right away unless it loops.
		set_reg(REG_GRID_COLUMNS, 24'd2);
		set_reg(REG_GRID_ROWS, 24'd2);
		set_reg(REG_CLIP_FIRST_CELL, 24'd3);
		set_reg(REG_CLIP_FRAMES, 24'd1);
		set_reg(REG_LOOP_ENABLE, 24'd0);
		set_reg(REG_FRAME_TICKS, 24'd1);
		send_tick(16'd0, 1'b1);
		send_tick(16'hFFFF, 1'b0);
		wait_drained();
		set_reg(REG_LOOP_ENABLE, 24'd1);
		send_tick(16'hFFFF, 1'b0);
		send_tick(16'd7, 1'b1);
		wait_drained();

		// Shrinking the clip mid-way leaves a clip time past the new end.
		set_reg(REG_LOOP_ENABLE, 24'd0);
		set_reg(REG_FRAME_TICKS, 24'd100);
		set_reg(REG_CLIP_FRAMES, 24'd50);
		send_tick(16'd4000, 1'b0);
		wait_drained();
		set_reg(REG_CLIP_FRAMES, 24'd10);
		send_tick(16'd0, 1'b0);
		wait_drained();

		phase = 0;
		while (ticks_sent < TICK_TARGET) begin
			shuffle_settings();
			// One long stretch with no idling on either side.
			idle_on = (phase != 3);
			burst = (phase == 3) ? 120 : $urandom_range(15, 60);
			if (phase == 6) begin
				hold_pending = 1'b1;
				burst = 40;
			end
			send_tick(pick_delta(), $urandom_range(1) != 0);
			repeat (burst - 1)
				send_tick(pick_delta(), $urandom_range(9) == 0);
			wait_drained();
			phase++;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		views.check_leftover();
		if (views.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
